// File: hw/rtl/bc_pkg.sv
package bc_pkg;

   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   localparam int unsigned PIX_PER_BLK = 16;

   // reciprocals for truncating division of the palette sums
   localparam logic [10:0] RECIP_THIRD   = 11'd683;   // /3, shift 11
   localparam logic [11:0] RECIP_FIFTH   = 12'd3277;  // /5, shift 14
   localparam logic [11:0] RECIP_SEVENTH = 12'd2341;  // /7, shift 14

   typedef enum logic [2:0] {
      DIV_ONE,
      DIV_HALF,
      DIV_THIRD,
      DIV_FIFTH,
      DIV_SEVENTH
   } div_type;

   // one pixel, straight out of the block register
   typedef struct packed {
      logic [15:0] c0;
      logic [15:0] c1;
      logic [7:0]  a0;
      logic [7:0]  a1;
      logic [1:0]  cidx;
      logic [3:0]  anib;
      logic [2:0]  aidx;
      logic [1:0]  fmt;
      logic [1:0]  px;
      logic [1:0]  py;
      logic        last;
   } pix_raw_type;

   // expanded endpoints and the weights of the selected palette entry
   typedef struct packed {
      logic [2:0][7:0] e0;
      logic [2:0][7:0] e1;
      logic [1:0]      cwa;
      logic [1:0]      cwb;
      div_type         cdiv;
      logic [7:0]      a0;
      logic [7:0]      a1;
      logic [2:0]      awa;
      logic [2:0]      awb;
      div_type         adiv;
      logic            aconst;
      logic [7:0]      aval;
      logic [1:0]      px;
      logic [1:0]      py;
      logic            last;
   } pix_wt_type;

   typedef struct packed {
      logic [2:0][9:0] csum;
      div_type         cdiv;
      logic [10:0]     asum;
      div_type         adiv;
      logic            aconst;
      logic [7:0]      aval;
      logic [1:0]      px;
      logic [1:0]      py;
      logic            last;
   } pix_sum_type;

endpackage

// File: hw/rtl/bc_blk_ser.sv
module bc_blk_ser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 blk_valid,
   output logic                 blk_ready,
   input  logic [63:0]          color_block,
   input  logic [63:0]          alpha_block,
   input  logic [1:0]           fmt,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bc_pkg::pix_raw_type  out_data
);
   import bc_pkg::*;

   logic [15:0] c0_ff, c0_in;
   logic [15:0] c1_ff, c1_in;
   logic [7:0]  a0_ff, a0_in;
   logic [7:0]  a1_ff, a1_in;
   logic [1:0]  fmt_ff, fmt_in;
   logic [31:0] cidx_ff, cidx_in;
   logic [63:0] anib_ff, anib_in;
   logic [47:0] aidx_ff, aidx_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        blk_vld_ff, blk_vld_in;

   logic        s0_vld_ff, s0_vld_in;
   pix_raw_type s0_ff, s0_in;

   logic s0_rdy;
   logic emit;
   logic last_emit;
   logic load;

   assign s0_rdy    = !s0_vld_ff || out_ready;
   assign emit      = blk_vld_ff && s0_rdy;
   assign last_emit = emit && (cnt_ff == 4'(PIX_PER_BLK - 1));
   // next block is taken in the cycle its predecessor's last pixel leaves
   assign blk_ready = !blk_vld_ff || last_emit;
   assign load      = blk_valid && blk_ready;

   always_comb begin
      c0_in      = c0_ff;
      c1_in      = c1_ff;
      a0_in      = a0_ff;
      a1_in      = a1_ff;
      fmt_in     = fmt_ff;
      cidx_in    = cidx_ff;
      anib_in    = anib_ff;
      aidx_in    = aidx_ff;
      cnt_in     = cnt_ff;
      blk_vld_in = blk_vld_ff;
      if (emit) begin
         cnt_in  = cnt_ff + 4'd1;
         cidx_in = {2'b00, cidx_ff[31:2]};
         anib_in = {4'b0000, anib_ff[63:4]};
         aidx_in = {3'b000, aidx_ff[47:3]};
      end
      if (last_emit) begin
         blk_vld_in = 1'b0;
      end
      if (load) begin
         c0_in      = color_block[15:0];
         c1_in      = color_block[31:16];
         cidx_in    = color_block[63:32];
         a0_in      = alpha_block[7:0];
         a1_in      = alpha_block[15:8];
         anib_in    = alpha_block;
         aidx_in    = alpha_block[63:16];
         fmt_in     = fmt;
         cnt_in     = 4'd0;
         blk_vld_in = 1'b1;
      end
   end

   always_comb begin
      s0_vld_in = s0_vld_ff;
      s0_in     = s0_ff;
      if (s0_rdy) begin
         s0_vld_in  = blk_vld_ff;
         s0_in.c0   = c0_ff;
         s0_in.c1   = c1_ff;
         s0_in.a0   = a0_ff;
         s0_in.a1   = a1_ff;
         s0_in.cidx = cidx_ff[1:0];
         s0_in.anib = anib_ff[3:0];
         s0_in.aidx = aidx_ff[2:0];
         s0_in.fmt  = fmt_ff;
         s0_in.px   = cnt_ff[1:0];
         s0_in.py   = cnt_ff[3:2];
         s0_in.last = (cnt_ff == 4'(PIX_PER_BLK - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_vld_ff <= 1'b0;
         cnt_ff     <= 4'd0;
         s0_vld_ff  <= 1'b0;
      end else begin
         blk_vld_ff <= blk_vld_in;
         cnt_ff     <= cnt_in;
         s0_vld_ff  <= s0_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff   <= c0_in;
      c1_ff   <= c1_in;
      a0_ff   <= a0_in;
      a1_ff   <= a1_in;
      fmt_ff  <= fmt_in;
      cidx_ff <= cidx_in;
      anib_ff <= anib_in;
      aidx_ff <= aidx_in;
      s0_ff   <= s0_in;
   end

   assign out_valid = s0_vld_ff;
   assign out_data  = s0_ff;

   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !blk_vld_ff |-> cnt_ff == 4'd0)
      else $error("pixel counter nonzero with no block held");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      last_emit |=> s0_vld_ff && s0_ff.last)
      else $error("sixteenth pixel not flagged last");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      s0_vld_ff && !out_ready |=> s0_vld_ff && $stable(s0_ff))
      else $error("stalled pixel changed");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      blk_vld_ff && !last_emit |-> !load)
      else $error("block loaded while previous block still serializing");

endmodule

// File: hw/rtl/bc_wsel.sv
module bc_wsel (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bc_pkg::pix_raw_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bc_pkg::pix_wt_type   out_data
);
   import bc_pkg::*;

   logic       vld_ff, vld_in;
   pix_wt_type wt_ff, wt_in;

   logic       three_mode;
   logic [2:0] j;

   assign in_ready = !vld_ff || out_ready;
   assign j        = in_data.aidx;

   always_comb begin
      three_mode = (in_data.fmt != FMT_DXT3) && (in_data.fmt != FMT_DXT5)
                   && (in_data.c0 <= in_data.c1);

      wt_in       = wt_ff;
      wt_in.e0[0] = {in_data.c0[15:11], in_data.c0[15:13]};
      wt_in.e0[1] = {in_data.c0[10:5], in_data.c0[10:9]};
      wt_in.e0[2] = {in_data.c0[4:0], in_data.c0[4:2]};
      wt_in.e1[0] = {in_data.c1[15:11], in_data.c1[15:13]};
      wt_in.e1[1] = {in_data.c1[10:5], in_data.c1[10:9]};
      wt_in.e1[2] = {in_data.c1[4:0], in_data.c1[4:2]};
      wt_in.a0    = in_data.a0;
      wt_in.a1    = in_data.a1;
      wt_in.px    = in_data.px;
      wt_in.py    = in_data.py;
      wt_in.last  = in_data.last;

      case (in_data.cidx)
         2'd0: begin
            wt_in.cwa  = 2'd1;
            wt_in.cwb  = 2'd0;
            wt_in.cdiv = DIV_ONE;
         end
         2'd1: begin
            wt_in.cwa  = 2'd0;
            wt_in.cwb  = 2'd1;
            wt_in.cdiv = DIV_ONE;
         end
         2'd2: begin
            wt_in.cwa  = three_mode ? 2'd1 : 2'd2;
            wt_in.cwb  = 2'd1;
            wt_in.cdiv = three_mode ? DIV_HALF : DIV_THIRD;
         end
         default: begin
            // black in three-color mode
            wt_in.cwa  = three_mode ? 2'd0 : 2'd1;
            wt_in.cwb  = three_mode ? 2'd0 : 2'd2;
            wt_in.cdiv = three_mode ? DIV_ONE : DIV_THIRD;
         end
      endcase

      wt_in.awa    = 3'd0;
      wt_in.awb    = 3'd0;
      wt_in.adiv   = DIV_ONE;
      wt_in.aconst = 1'b1;
      wt_in.aval   = (three_mode && in_data.cidx == 2'd3) ? 8'd0 : 8'd255;
      if (in_data.fmt == FMT_DXT3) begin
         wt_in.aval = {in_data.anib, in_data.anib};
      end else if (in_data.fmt == FMT_DXT5) begin
         wt_in.aconst = 1'b0;
         if (j == 3'd0) begin
            wt_in.awa = 3'd1;
         end else if (j == 3'd1) begin
            wt_in.awb = 3'd1;
         end else if (in_data.a0 > in_data.a1) begin
            wt_in.awa  = 3'(4'd8 - {1'b0, j});
            wt_in.awb  = j - 3'd1;
            wt_in.adiv = DIV_SEVENTH;
         end else if (j < 3'd6) begin
            wt_in.awa  = 3'(4'd6 - {1'b0, j});
            wt_in.awb  = j - 3'd1;
            wt_in.adiv = DIV_FIFTH;
         end else begin
            wt_in.aconst = 1'b1;
            wt_in.aval   = (j == 3'd7) ? 8'd255 : 8'd0;
         end
      end
   end

   always_comb begin
      vld_in = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         wt_ff <= wt_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = wt_ff;

endmodule

// File: hw/rtl/bc_wsum.sv
module bc_wsum (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bc_pkg::pix_wt_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output bc_pkg::pix_sum_type  out_data
);
   import bc_pkg::*;

   logic        vld_ff, vld_in;
   pix_sum_type sum_ff, sum_in;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in.csum[ch] = 10'(in_data.cwa) * 10'(in_data.e0[ch])
                         + 10'(in_data.cwb) * 10'(in_data.e1[ch]);
      end
      sum_in.asum   = 11'(in_data.awa) * 11'(in_data.a0)
                    + 11'(in_data.awb) * 11'(in_data.a1);
      sum_in.cdiv   = in_data.cdiv;
      sum_in.adiv   = in_data.adiv;
      sum_in.aconst = in_data.aconst;
      sum_in.aval   = in_data.aval;
      sum_in.px     = in_data.px;
      sum_in.py     = in_data.py;
      sum_in.last   = in_data.last;
      vld_in        = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = sum_ff;

endmodule

// File: hw/rtl/bc_scale.sv
module bc_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  bc_pkg::pix_sum_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           red,
   output logic [7:0]           green,
   output logic [7:0]           blue,
   output logic [7:0]           alpha,
   output logic [1:0]           pixel_x,
   output logic [1:0]           pixel_y,
   output logic                 last_pixel
);
   import bc_pkg::*;

   logic            vld_ff, vld_in;
   logic [2:0][7:0] rgb_ff, rgb_in;
   logic [7:0]      alpha_ff, alpha_in;
   logic [1:0]      px_ff, py_ff;
   logic            last_ff;

   logic [2:0][20:0] cprod;
   logic [24:0]      aprod5;
   logic [24:0]      aprod7;

   assign in_ready = !vld_ff || out_ready;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         cprod[ch] = 21'(in_data.csum[ch]) * 21'(RECIP_THIRD);
         case (in_data.cdiv)
            DIV_HALF:  rgb_in[ch] = in_data.csum[ch][8:1];
            DIV_THIRD: rgb_in[ch] = cprod[ch][18:11];
            default:   rgb_in[ch] = in_data.csum[ch][7:0];
         endcase
      end
      aprod5 = 25'(in_data.asum) * 25'(RECIP_FIFTH);
      aprod7 = 25'(in_data.asum) * 25'(RECIP_SEVENTH);
      if (in_data.aconst) begin
         alpha_in = in_data.aval;
      end else begin
         case (in_data.adiv)
            DIV_FIFTH:   alpha_in = aprod5[21:14];
            DIV_SEVENTH: alpha_in = aprod7[21:14];
            default:     alpha_in = in_data.asum[7:0];
         endcase
      end
      vld_in = in_ready ? in_valid : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rgb_ff   <= rgb_in;
         alpha_ff <= alpha_in;
         px_ff    <= in_data.px;
         py_ff    <= in_data.py;
         last_ff  <= in_data.last;
      end
   end

   assign out_valid  = vld_ff;
   assign red        = rgb_ff[0];
   assign green      = rgb_ff[1];
   assign blue       = rgb_ff[2];
   assign alpha      = alpha_ff;
   assign pixel_x    = px_ff;
   assign pixel_y    = py_ff;
   assign last_pixel = last_ff;

endmodule

// File: hw/rtl/bc1_bc2_bc3_block_decoder_top.sv
// channel  dir  word                              handshake
// req      in   one compressed 4x4 block          req_tvalid / req_tready
// rsp      out  one RGBA pixel, raster order      rsp_tvalid / rsp_tready, rsp_tlast
// csr      in   block format (0 DXT1, 1 DXT3, 2 DXT5)  csr_wen, no wait
//
// Each block yields 16 pixel words, one per cycle while rsp is not stalled,
// counted by the pixel counter in the block register. The first pixel word
// passes the block register and the unpack, weights, sums and scale regs.
// The next block is taken in the cycle the last pixel of the current one
// leaves the block register. Reset is synchronous and clears all valids and
// the format (DXT1). A stall on rsp holds every stage; nothing is dropped.
module bc1_bc2_bc3_block_decoder_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // [63:0] color_block, [127:64] alpha_block
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [39:0]   rsp_tdata,   // red, green, blue, alpha, pixel_x, pixel_y, pad
   output logic          rsp_tlast,   // last_pixel
   input  logic          csr_wen,
   input  logic [1:0]    csr_wdata    // block_format
);
   import bc_pkg::*;

   logic [1:0] fmt_ff, fmt_in;

   logic        raw_vld, raw_rdy;
   pix_raw_type raw_data;
   logic        wt_vld, wt_rdy;
   pix_wt_type  wt_data;
   logic        sum_vld, sum_rdy;
   pix_sum_type sum_data;

   logic [7:0] red, green, blue, alpha;
   logic [1:0] pixel_x, pixel_y;

   assign fmt_in = csr_wen ? csr_wdata : fmt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_DXT1;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   bc_blk_ser u_ser (
      .clock       (clock),
      .reset       (reset),
      .blk_valid   (req_tvalid),
      .blk_ready   (req_tready),
      .color_block (req_tdata[63:0]),
      .alpha_block (req_tdata[127:64]),
      .fmt         (fmt_ff),
      .out_valid   (raw_vld),
      .out_ready   (raw_rdy),
      .out_data    (raw_data)
   );

   bc_wsel u_wsel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (raw_vld),
      .in_ready  (raw_rdy),
      .in_data   (raw_data),
      .out_valid (wt_vld),
      .out_ready (wt_rdy),
      .out_data  (wt_data)
   );

   bc_wsum u_wsum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wt_vld),
      .in_ready  (wt_rdy),
      .in_data   (wt_data),
      .out_valid (sum_vld),
      .out_ready (sum_rdy),
      .out_data  (sum_data)
   );

   bc_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sum_vld),
      .in_ready   (sum_rdy),
      .in_data    (sum_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .red        (red),
      .green      (green),
      .blue       (blue),
      .alpha      (alpha),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .last_pixel (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, pixel_y, pixel_x, alpha, blue, green, red};

endmodule
